// ----- rtl/brsct_pkg.sv -----
// shared types and constants of the bitmap rectangle block
`default_nettype none

package brsct_pkg;

  localparam int GRID_SIZE_DEF = 1024;
  localparam int COORD_W       = 10;
  localparam int CMD_W         = 2;
  localparam int LIT_W         = 21;
  localparam int WORD_W        = 64;
  localparam int OFF_W         = 6;
  localparam int QUEUE_DEPTH   = 4;
  localparam int RAM_DEPTH_DEF = 16384;

  localparam logic [CMD_W-1:0] OP_INVERT = 2'd0;
  localparam logic [CMD_W-1:0] OP_SET    = 2'd1;
  localparam logic [CMD_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic               active;
    logic [CMD_W-1:0]   op;
    logic [COORD_W-1:0] row_lo;
    logic [COORD_W-1:0] row_hi;
    logic [COORD_W-1:0] col_lo;
    logic [COORD_W-1:0] col_hi;
  } rect_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/brsct_cmd_if.sv -----
// command channel interface
`default_nettype none

interface brsct_cmd_if;
  import brsct_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [COORD_W-1:0] row_start;
  logic [COORD_W-1:0] col_start;
  logic [COORD_W-1:0] row_end;
  logic [COORD_W-1:0] col_end;

  modport source (output valid, cmd, row_start, col_start, row_end, col_end, input ready);
  modport sink   (input valid, cmd, row_start, col_start, row_end, col_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/brsct_res_if.sv -----
// result channel interface
`default_nettype none

interface brsct_res_if;
  import brsct_pkg::*;

  logic             valid;
  logic             ready;
  logic [LIT_W-1:0] lit_total;

  modport source (output valid, lit_total, input ready);
  modport sink   (input valid, lit_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/brsct_ram.sv -----
// generic single-write, single-read ram with registered read
`default_nettype none

module brsct_ram #(
  parameter int WIDTH = brsct_pkg::WORD_W,
  parameter int DEPTH = brsct_pkg::RAM_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/brsct_front.sv -----
// command front end: accepts, validates and clips rectangles
`default_nettype none

module brsct_front #(
  parameter int GRID_SIZE = brsct_pkg::GRID_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  brsct_cmd_if.sink          in_ch,
  input  wire logic          clr_busy,
  output logic               push_valid,
  input  wire logic          push_ready,
  output brsct_pkg::rect_cmd_t push_cmd
);
  import brsct_pkg::*;

  localparam int LG = $clog2(GRID_SIZE);
  localparam int XW = (LG > COORD_W) ? LG : COORD_W;
  localparam logic [XW-1:0] TOP = XW'(GRID_SIZE - 1);

  logic            hold_valid_r;
  logic            hold_valid_nxt;
  rect_cmd_t       hold_r;
  rect_cmd_t       cls;
  logic            accept;
  logic [XW-1:0]   r0_x;
  logic [XW-1:0]   r1_x;
  logic [XW-1:0]   c0_x;
  logic [XW-1:0]   c1_x;

  assign r0_x = XW'(in_ch.row_start);
  assign r1_x = XW'(in_ch.row_end);
  assign c0_x = XW'(in_ch.col_start);
  assign c1_x = XW'(in_ch.col_end);

  always_comb begin
    cls.active = (in_ch.cmd <= OP_CLEAR) && (r0_x <= r1_x) && (c0_x <= c1_x)
                 && (r0_x <= TOP) && (c0_x <= TOP);
    cls.op     = in_ch.cmd;
    cls.row_lo = in_ch.row_start;
    cls.col_lo = in_ch.col_start;
    cls.row_hi = COORD_W'((r1_x > TOP) ? TOP : r1_x);
    cls.col_hi = COORD_W'((c1_x > TOP) ? TOP : c1_x);
  end

  assign in_ch.ready = !clr_busy && (!hold_valid_r || push_ready);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= cls;
    end
  end

  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_r;

endmodule

`default_nettype wire

// ----- rtl/brsct_queue.sv -----
// short command queue between front end and sweep engine
`default_nettype none

module brsct_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire brsct_pkg::rect_cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output brsct_pkg::rect_cmd_t pop_cmd
);
  import brsct_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  rect_cmd_t     slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   fill_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill_r != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/brsct_back.sv -----
// sweep engine: word-wide read-modify-write over the bitmap ram and set-cell count
`default_nettype none

module brsct_back #(
  parameter int GRID_SIZE = brsct_pkg::GRID_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire brsct_pkg::rect_cmd_t pop_cmd,
  output logic               clr_busy,
  brsct_res_if.source        out_ch
);
  import brsct_pkg::*;

  localparam int LG    = $clog2(GRID_SIZE);
  localparam int AW    = 2 * LG;
  localparam int AWP   = (AW > OFF_W) ? AW : OFF_W + 1;
  localparam int WAW   = AWP - OFF_W;
  localparam int DEPTH = 1 << WAW;
  localparam int CNTW  = AW + 1;
  localparam logic [CNTW-1:0] CELLS = CNTW'(GRID_SIZE * GRID_SIZE);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  function automatic logic [OFF_W:0] ones_in(input logic [WORD_W-1:0] x);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    ones_in = {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic [WAW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CMD_W-1:0]   op_r, op_nxt;
  logic [LG-1:0]      row_r, row_nxt;
  logic [LG-1:0]      row_hi_r, row_hi_nxt;
  logic [LG-1:0]      col_lo_r, col_lo_nxt;
  logic [LG-1:0]      col_hi_r, col_hi_nxt;
  logic [WAW-1:0]     w_r, w_nxt;
  logic [WAW-1:0]     wfirst_r, wfirst_nxt;
  logic [WAW-1:0]     wlast_r, wlast_nxt;
  logic [OFF_W-1:0]   lo_off_r, lo_off_nxt;
  logic [OFF_W-1:0]   hi_off_r, hi_off_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LIT_W-1:0]   lit_r, lit_nxt;

  logic [LG-1:0]      row_sel;
  logic [LG-1:0]      cl_sel;
  logic [LG-1:0]      ch_sel;
  logic [AWP-1:0]     lo_a;
  logic [AWP-1:0]     hi_a;

  logic               issue;
  logic [WORD_W-1:0]  mask_i;
  logic               b_valid_r;
  logic [WAW-1:0]     b_addr_r;
  logic [WORD_W-1:0]  b_mask_r;
  logic               fwd_r;
  logic [WORD_W-1:0]  fwd_data_r;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WORD_W-1:0]  old_w;
  logic [WORD_W-1:0]  new_w;
  logic [OFF_W:0]     pop_before;
  logic [OFF_W:0]     pop_after;
  logic               c_valid_r;
  logic signed [7:0]  delta_r;
  logic [CNTW-1:0]    cnt_r;

  logic               ram_we;
  logic [WAW-1:0]     ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;

  // row setup: first row from the queue, following rows from the registers
  always_comb begin
    if (state_r == ST_IDLE) begin
      row_sel = LG'(pop_cmd.row_lo);
      cl_sel  = LG'(pop_cmd.col_lo);
      ch_sel  = LG'(pop_cmd.col_hi);
    end else begin
      row_sel = row_r + LG'(1);
      cl_sel  = col_lo_r;
      ch_sel  = col_hi_r;
    end
    lo_a = AWP'({row_sel, cl_sel});
    hi_a = AWP'({row_sel, ch_sel});
  end

  assign pop_ready = (state_r == ST_IDLE);
  assign clr_busy  = (state_r == ST_CLR);
  assign issue     = (state_r == ST_RUN);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    row_hi_nxt    = row_hi_r;
    col_lo_nxt    = col_lo_r;
    col_hi_nxt    = col_hi_r;
    w_nxt         = w_r;
    wfirst_nxt    = wfirst_r;
    wlast_nxt     = wlast_r;
    lo_off_nxt    = lo_off_r;
    hi_off_nxt    = hi_off_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    lit_nxt       = lit_r;
    unique case (state_r)
      ST_CLR: begin
        clr_addr_nxt = clr_addr_r + WAW'(1);
        if (clr_addr_r == WAW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid) begin
          op_nxt     = pop_cmd.op;
          row_hi_nxt = LG'(pop_cmd.row_hi);
          col_lo_nxt = cl_sel;
          col_hi_nxt = ch_sel;
          row_nxt    = row_sel;
          w_nxt      = lo_a[AWP-1:OFF_W];
          wfirst_nxt = lo_a[AWP-1:OFF_W];
          wlast_nxt  = hi_a[AWP-1:OFF_W];
          lo_off_nxt = lo_a[OFF_W-1:0];
          hi_off_nxt = hi_a[OFF_W-1:0];
          state_nxt  = pop_cmd.active ? ST_RUN : ST_RESP;
        end
      end
      ST_RUN: begin
        if (w_r == wlast_r) begin
          if (row_r == row_hi_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            row_nxt    = row_sel;
            w_nxt      = lo_a[AWP-1:OFF_W];
            wfirst_nxt = lo_a[AWP-1:OFF_W];
            wlast_nxt  = hi_a[AWP-1:OFF_W];
            lo_off_nxt = lo_a[OFF_W-1:0];
            hi_off_nxt = hi_a[OFF_W-1:0];
          end
        end else begin
          w_nxt = w_r + WAW'(1);
        end
      end
      ST_DRAIN: begin
        if (!b_valid_r && !c_valid_r) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          lit_nxt       = LIT_W'(cnt_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // mask of the word being issued
  always_comb begin
    mask_i = {WORD_W{1'b1}};
    if (w_r == wfirst_r) begin
      mask_i = mask_i & ({WORD_W{1'b1}} << lo_off_r);
    end
    if (w_r == wlast_r) begin
      mask_i = mask_i & ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - hi_off_r));
    end
  end

  // modify stage, with forwarding of a word written in the read cycle
  always_comb begin
    old_w = fwd_r ? fwd_data_r : ram_rdata;
    unique case (op_r)
      OP_INVERT: new_w = old_w ^ b_mask_r;
      OP_SET:    new_w = old_w | b_mask_r;
      OP_CLEAR:  new_w = old_w & ~b_mask_r;
      default:   new_w = old_w;
    endcase
    pop_before = ones_in(old_w & b_mask_r);
    pop_after  = ones_in(new_w & b_mask_r);
  end

  assign ram_we    = clr_busy || b_valid_r;
  assign ram_waddr = clr_busy ? clr_addr_r : b_addr_r;
  assign ram_wdata = clr_busy ? '0 : new_w;

  brsct_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (w_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      b_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      c_valid_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      b_valid_r   <= issue;
      fwd_r       <= issue && b_valid_r && (w_r == b_addr_r);
      c_valid_r   <= b_valid_r;
      if (c_valid_r) begin
        cnt_r <= cnt_r + CNTW'(delta_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    row_r      <= row_nxt;
    row_hi_r   <= row_hi_nxt;
    col_lo_r   <= col_lo_nxt;
    col_hi_r   <= col_hi_nxt;
    w_r        <= w_nxt;
    wfirst_r   <= wfirst_nxt;
    wlast_r    <= wlast_nxt;
    lo_off_r   <= lo_off_nxt;
    hi_off_r   <= hi_off_nxt;
    lit_r      <= lit_nxt;
    b_addr_r   <= w_r;
    b_mask_r   <= mask_i;
    fwd_data_r <= new_w;
    delta_r    <= $signed({1'b0, pop_after}) - $signed({1'b0, pop_before});
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.lit_total = lit_r;

  a_clr_no_modify: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !b_valid_r)
    else $error("modify stage active during clearing pass");

  a_fwd_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> b_valid_r)
    else $error("forwarded word without a word in the modify stage");

  a_resp_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) |-> (!b_valid_r && !c_valid_r))
    else $error("result taken before the sweep pipeline drained");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CELLS)
    else $error("set-cell count beyond grid size");

endmodule

`default_nettype wire

// ----- rtl/bitmap_rectangle_set_clear_toggle_top.sv -----
// top level of the bitmap rectangle set / clear / invert block
//
//   channel   dir   handshake       payload
//   in_ch     in    valid / ready   cmd, row_start, col_start, row_end, col_end
//   out_ch    out   valid / ready   lit_total
//
// one 64-bit bitmap word per cycle through a single ram read-modify-write loop
// N word accesses (sum over rows of last word - first word + 1) hold the sweep engine
//   in its run state, then drain and response; a no-op command goes straight to response
// a full grid is GRID_SIZE*max(1, GRID_SIZE/64) accesses (16384 at 1024)
// after reset a clearing pass zeroes every ram word with in_ch.ready low
// a 4-entry command queue lets in_ch accept while a sweep runs; out_ch holds its result
//   in a register, and a stalled out_ch only stops the sweep engine at the next result
`default_nettype none

module bitmap_rectangle_set_clear_toggle_top #(
  parameter int GRID_SIZE = brsct_pkg::GRID_SIZE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  brsct_cmd_if.sink   in_ch,
  brsct_res_if.source out_ch
);
  import brsct_pkg::*;

  logic      push_valid;
  logic      push_ready;
  rect_cmd_t push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  rect_cmd_t pop_cmd;
  logic      clr_busy;

  brsct_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .clr_busy   (clr_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  brsct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  brsct_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .clr_busy  (clr_busy),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
